/* sv/mgs_pkg.sv */
// Package: shared types, command codes and the note frequency table.
`default_nettype none
package mgs_pkg;

  localparam int NOTE_COUNT = 84;
  localparam int DIV_STEPS  = 13;

  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_LOAD = 2'd1;
  localparam logic [1:0] CMD_PLAY = 2'd2;
  localparam logic [1:0] CMD_STOP = 2'd3;

  localparam logic CFG_SEQ_LENGTH = 1'b0;
  localparam logic CFG_LOOP_COUNT = 1'b1;

  localparam logic [12:0] FREQ_TABLE [NOTE_COUNT] = '{
    13'd65,   13'd69,   13'd73,   13'd77,   13'd82,   13'd87,
    13'd92,   13'd98,   13'd103,  13'd110,  13'd116,  13'd123,
    13'd130,  13'd138,  13'd146,  13'd155,  13'd164,  13'd174,
    13'd185,  13'd196,  13'd207,  13'd220,  13'd233,  13'd246,
    13'd261,  13'd277,  13'd293,  13'd311,  13'd330,  13'd349,
    13'd370,  13'd392,  13'd415,  13'd440,  13'd466,  13'd494,
    13'd523,  13'd554,  13'd587,  13'd622,  13'd659,  13'd699,
    13'd740,  13'd784,  13'd831,  13'd880,  13'd932,  13'd988,
    13'd1047, 13'd1109, 13'd1175, 13'd1245, 13'd1319, 13'd1397,
    13'd1480, 13'd1568, 13'd1661, 13'd1760, 13'd1865, 13'd1976,
    13'd2093, 13'd2217, 13'd2349, 13'd2489, 13'd2637, 13'd2794,
    13'd2960, 13'd3136, 13'd3322, 13'd3520, 13'd3729, 13'd3951,
    13'd4186, 13'd4435, 13'd4699, 13'd4978, 13'd5274, 13'd5588,
    13'd5920, 13'd6272, 13'd6645, 13'd7040, 13'd7459, 13'd7902
  };

  typedef struct packed {
    logic accept;
    logic load;
    logic play;
    logic stop;
    logic silence_all;
    logic fix_step;
    logic rd_cur;
    logic cmp;
    logic rd_next;
    logic lat_next;
    logic mul;
    logic add;
    logic div_step;
    logic glide_tone;
    logic finish;
  } ctl_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       tick_idle;
    logic       loops_zero;
    logic       note_rest;
    logic       glide;
    logic       div_last;
  } sts_t;

  function automatic logic is_rest(input logic signed [7:0] n);
    is_rest = n[7] || (n[6:0] >= 7'(NOTE_COUNT));
  endfunction

  function automatic logic [12:0] freq_of(input logic signed [7:0] n);
    logic [12:0] f;
    f = '0;
    if (!is_rest(n)) begin
      f = FREQ_TABLE[n[6:0]];
    end
    freq_of = f;
  endfunction

endpackage
`default_nettype wire

/* sv/mgs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mgs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* sv/mgs_ctrl.sv */
// Controller state machine: sequences each item through the datapath.
`default_nettype none
module mgs_ctrl
  import mgs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire logic out_stall,
  output logic      out_valid,
  input  wire sts_t sts,
  output ctl_t      ctl
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DEC  = 4'd1;
  localparam logic [3:0] S_RD0  = 4'd2;
  localparam logic [3:0] S_CMP  = 4'd3;
  localparam logic [3:0] S_CHK  = 4'd4;
  localparam logic [3:0] S_NOTE = 4'd5;
  localparam logic [3:0] S_NEXT = 4'd6;
  localparam logic [3:0] S_MUL  = 4'd7;
  localparam logic [3:0] S_ADD  = 4'd8;
  localparam logic [3:0] S_DIV  = 4'd9;
  localparam logic [3:0] S_TONE = 4'd10;
  localparam logic [3:0] S_FIN  = 4'd11;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.accept = 1'b1;
          state_nxt  = S_DEC;
        end
      end
      S_DEC: begin
        case (sts.cmd)
          CMD_LOAD: begin
            ctl.load  = 1'b1;
            state_nxt = S_FIN;
          end
          CMD_PLAY: begin
            ctl.play  = 1'b1;
            state_nxt = S_FIN;
          end
          CMD_STOP: begin
            ctl.stop  = 1'b1;
            state_nxt = S_FIN;
          end
          default: begin
            if (sts.tick_idle) begin
              ctl.silence_all = 1'b1;
              state_nxt       = S_FIN;
            end else begin
              ctl.fix_step = 1'b1;
              state_nxt    = S_RD0;
            end
          end
        endcase
      end
      S_RD0: begin
        ctl.rd_cur = 1'b1;
        state_nxt  = S_CMP;
      end
      S_CMP: begin
        ctl.cmp   = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (sts.loops_zero) begin
          state_nxt = S_FIN;
        end else begin
          ctl.rd_cur = 1'b1;
          state_nxt  = S_NOTE;
        end
      end
      S_NOTE: begin
        ctl.rd_next = 1'b1;
        state_nxt   = S_NEXT;
      end
      S_NEXT: begin
        ctl.lat_next = 1'b1;
        if (!sts.note_rest && sts.glide) begin
          state_nxt = S_MUL;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_MUL: begin
        ctl.mul   = 1'b1;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        ctl.add   = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        ctl.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_TONE;
        end
      end
      S_TONE: begin
        ctl.glide_tone = 1'b1;
        state_nxt      = S_FIN;
      end
      S_FIN: begin
        if (slot_free) begin
          ctl.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (ctl.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end
endmodule
`default_nettype wire

/* sv/mgs_datapath.sv */
// Datapath: tables, step timing, glide multiply and iterative divide, result registers.
`default_nettype none
module mgs_datapath
  import mgs_pkg::*;
#(
  parameter int MAX_STEPS = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [8:0]         cfg_wdata,
  input  wire logic [1:0]         in_command,
  input  wire logic [31:0]        in_now_ms,
  input  wire logic [5:0]         in_entry_index,
  input  wire logic signed [7:0]  in_entry_note,
  input  wire logic signed [15:0] in_entry_duration,
  output logic                    out_sound_on,
  output logic [12:0]             out_frequency_hz,
  output logic                    out_drive_enable,
  output logic [5:0]              out_step_index,
  output logic                    out_playing,
  input  wire ctl_t               ctl,
  output sts_t                    sts
);
  localparam int IW = $clog2(MAX_STEPS);

  logic [6:0]         seq_len_r;
  logic signed [8:0]  loop_cnt_r;
  logic [1:0]         cmd_r;
  logic [31:0]        now_r;
  logic [5:0]         idx_r;
  logic signed [7:0]  enote_r;
  logic signed [15:0] edur_r;

  logic [IW-1:0]      step_r;
  logic [31:0]        start_r;
  logic signed [8:0]  loops_r;
  logic [12:0]        freq_r;
  logic               sound_r;
  logic               drive_r;

  logic [15:0]        el_r;
  logic signed [7:0]  note_r;
  logic signed [15:0] dur_r;
  logic [12:0]        f1_r;
  logic [12:0]        f2_r;
  logic [15:0]        d_r;
  logic [15:0]        e_r;
  logic [28:0]        p1_r;
  logic [28:0]        p2_r;
  logic [15:0]        rem_r;
  logic [12:0]        q_r;
  logic [3:0]         cnt_r;

  logic [31:0]        len32;
  logic [31:0]        step32;
  logic [31:0]        step_inc32;
  logic [IW-1:0]      next_step;
  logic               idx_ok;
  logic               ram_we;
  logic [IW-1:0]      ram_raddr;
  logic [23:0]        ram_rdata;
  logic signed [7:0]  rd_note;
  logic [15:0]        rd_mag;
  logic [15:0]        dur_mag;
  logic [31:0]        elapsed;
  logic [28:0]        num;
  logic [16:0]        trial;
  logic               ge;

  assign len32      = (32'(seq_len_r) > 32'(MAX_STEPS)) ? 32'(MAX_STEPS) : 32'(seq_len_r);
  assign step32     = 32'(step_r);
  assign step_inc32 = step32 + 32'd1;
  assign next_step  = (step_inc32 >= len32) ? '0 : IW'(step_inc32);
  assign idx_ok     = (32'(idx_r) < 32'(MAX_STEPS));
  assign ram_we     = ctl.load && idx_ok;
  assign ram_raddr  = ctl.rd_next ? next_step : step_r;
  assign rd_note    = $signed(ram_rdata[23:16]);
  assign rd_mag     = ram_rdata[15] ? (~ram_rdata[15:0] + 16'd1) : ram_rdata[15:0];
  assign dur_mag    = dur_r[15] ? (~dur_r + 16'd1) : dur_r;
  assign elapsed    = now_r - start_r;
  assign num        = p1_r + p2_r;
  assign trial      = {rem_r, q_r[12]};
  assign ge         = (trial >= {1'b0, d_r});

  assign sts.cmd        = cmd_r;
  assign sts.tick_idle  = (len32 == 32'd0) || (loops_r == 9'sd0);
  assign sts.loops_zero = (loops_r == 9'sd0);
  assign sts.note_rest  = is_rest(note_r);
  assign sts.glide      = dur_r[15] && !is_rest(rd_note) && (dur_mag != 16'd0);
  assign sts.div_last   = (cnt_r == 4'(DIV_STEPS - 1));

  mgs_ram #(
    .WIDTH(24),
    .DEPTH(MAX_STEPS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(IW'(idx_r)),
    .wdata({enote_r, edur_r}),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_len_r  <= '0;
      loop_cnt_r <= 9'sd1;
    end else if (cfg_we) begin
      if (cfg_index == CFG_SEQ_LENGTH) begin
        seq_len_r <= cfg_wdata[6:0];
      end else begin
        loop_cnt_r <= $signed(cfg_wdata);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      cmd_r   <= in_command;
      now_r   <= in_now_ms;
      idx_r   <= in_entry_index;
      enote_r <= in_entry_note;
      edur_r  <= in_entry_duration;
    end
    if (ctl.rd_next) begin
      note_r <= rd_note;
      dur_r  <= $signed(ram_rdata[15:0]);
    end
    if (ctl.lat_next) begin
      f1_r <= freq_of(note_r);
      f2_r <= freq_of(rd_note);
      d_r  <= dur_mag;
      e_r  <= (el_r > dur_mag) ? dur_mag : el_r;
    end
    if (ctl.mul) begin
      p1_r <= 29'(f1_r) * 29'(d_r - e_r);
      p2_r <= 29'(f2_r) * 29'(e_r);
    end
    if (ctl.add) begin
      rem_r <= num[28:13];
      q_r   <= num[12:0];
      cnt_r <= '0;
    end else if (ctl.div_step) begin
      rem_r <= ge ? 16'(trial - {1'b0, d_r}) : trial[15:0];
      q_r   <= {q_r[11:0], ge};
      cnt_r <= cnt_r + 4'd1;
    end
    if (ctl.cmp) begin
      el_r <= (elapsed > {16'd0, rd_mag}) ? 16'd0 : elapsed[15:0];
    end
    if (ctl.finish) begin
      out_sound_on     <= sound_r;
      out_frequency_hz <= freq_r;
      out_drive_enable <= drive_r;
      out_step_index   <= 6'(step_r);
      out_playing      <= (loops_r != 9'sd0) && (len32 != 32'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= '0;
      start_r <= '0;
      loops_r <= '0;
      freq_r  <= '0;
      sound_r <= 1'b0;
      drive_r <= 1'b0;
    end else begin
      if (ctl.play) begin
        step_r  <= '0;
        start_r <= now_r;
        loops_r <= loop_cnt_r;
        drive_r <= 1'b1;
      end
      if (ctl.stop) begin
        loops_r <= '0;
      end
      if (ctl.silence_all) begin
        sound_r <= 1'b0;
        freq_r  <= '0;
        drive_r <= 1'b0;
      end
      if (ctl.fix_step && (step32 >= len32)) begin
        step_r <= '0;
      end
      if (ctl.cmp && (elapsed > {16'd0, rd_mag})) begin
        start_r <= now_r;
        if (step_inc32 >= len32) begin
          step_r <= '0;
          if (loops_r > 9'sd0) begin
            loops_r <= loops_r - 9'sd1;
          end
        end else begin
          step_r <= IW'(step_inc32);
        end
      end
      if (ctl.lat_next) begin
        if (sts.note_rest) begin
          sound_r <= 1'b0;
          freq_r  <= '0;
        end else if (!sts.glide) begin
          sound_r <= 1'b1;
          freq_r  <= freq_of(note_r);
        end
      end
      if (ctl.glide_tone) begin
        sound_r <= 1'b1;
        freq_r  <= q_r;
      end
    end
  end
endmodule
`default_nettype wire

/* sv/melody_glide_sequencer.sv */
// Top level: melody sequencer with glide, controller plus datapath.
//
//  channel | direction | handshake         | payload
//  in_     | input     | in_valid/in_stall   | command, now_ms, entry_*
//  out_    | output    | out_valid/out_stall | sound_on, frequency_hz, drive_enable,
//          |           |                     | step_index, playing
//  cfg_    | input     | cfg_we              | cfg_index, cfg_wdata
//
// One item at a time: load, play and stop pass through decode and finish only; a playing
// tick also reads and compares the table, and a glide adds the 13-step restoring divider.
// Table reads go through one registered-read RAM port, one read per cycle.
// Reset is synchronous; table contents are not cleared.
// in_stall is high from acceptance until the result enters the output register;
// a stalled output holds its item while the next item is worked on.
`default_nettype none
module melody_glide_sequencer
  import mgs_pkg::*;
#(
  parameter int MAX_STEPS = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [8:0]         cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_command,
  input  wire logic [31:0]        in_now_ms,
  input  wire logic [5:0]         in_entry_index,
  input  wire logic signed [7:0]  in_entry_note,
  input  wire logic signed [15:0] in_entry_duration,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_sound_on,
  output logic [12:0]             out_frequency_hz,
  output logic                    out_drive_enable,
  output logic [5:0]              out_step_index,
  output logic                    out_playing
);
  ctl_t ctl;
  sts_t sts;

  mgs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .sts      (sts),
    .ctl      (ctl)
  );

  mgs_datapath #(
    .MAX_STEPS(MAX_STEPS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_command       (in_command),
    .in_now_ms        (in_now_ms),
    .in_entry_index   (in_entry_index),
    .in_entry_note    (in_entry_note),
    .in_entry_duration(in_entry_duration),
    .out_sound_on     (out_sound_on),
    .out_frequency_hz (out_frequency_hz),
    .out_drive_enable (out_drive_enable),
    .out_step_index   (out_step_index),
    .out_playing      (out_playing),
    .ctl              (ctl),
    .sts              (sts)
  );
endmodule
`default_nettype wire

/* sv/mgs_checker.sv */
// Port-level checker for the melody sequencer, bound to the top level.
`default_nettype none
module mgs_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        out_sound_on,
  input wire logic [12:0] out_frequency_hz
);
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("item accepted while another is in work");

  a_silent_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_sound_on) |-> (out_frequency_hz == 13'd0))
    else $error("frequency nonzero while silent");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled item dropped");
endmodule

bind melody_glide_sequencer mgs_checker u_mgs_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_sound_on    (out_sound_on),
  .out_frequency_hz(out_frequency_hz)
);
`default_nettype wire

/* test/testbench.sv */
// Testbench for melody_glide_sequencer: directed table plus random melodies.
`default_nettype none
module testbench
  import mgs_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        sound;
    logic [12:0] freq;
    logic        drive;
    logic [5:0]  step;
    logic        playing;
  } tone_t;

  typedef struct {
    logic [1:0]         cmd;
    logic [31:0]        now;
    logic [5:0]         idx;
    logic signed [7:0]  note;
    logic signed [15:0] dur;
    logic               has_exp;
    tone_t              exp_tone;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [8:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_command = CMD_TICK;
  logic [31:0] in_now_ms = '0;
  logic [5:0] in_entry_index = '0;
  logic signed [7:0] in_entry_note = '0;
  logic signed [15:0] in_entry_duration = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_sound_on;
  logic [12:0] out_frequency_hz;
  logic out_drive_enable;
  logic [5:0] out_step_index;
  logic out_playing;

  melody_glide_sequencer u_top (.*);

  always #5 clk = ~clk;

  // predictor state
  logic [6:0] m_len;
  logic signed [8:0] m_loop_cfg;
  logic signed [7:0] m_notes [64];
  logic signed [15:0] m_durs [64];
  logic [5:0] m_step;
  logic [31:0] m_start;
  logic signed [8:0] m_loops;
  logic [12:0] m_freq;
  logic m_sound, m_drive;

  tone_t expected_tones [$];
  int errors = 0;
  int results_seen = 0;
  int cycles = 0;
  int out_wait = 0;
  logic [31:0] clock_ms = 0;

  function automatic logic note_rest(logic signed [7:0] n);
    return n < 0 || n >= NOTE_COUNT;
  endfunction

  function automatic int eff_len();
    return m_len > 64 ? 64 : int'(m_len);
  endfunction

  function automatic tone_t predict_tone(row_t r);
    int len;
    logic [31:0] el, d, e;
    longint f1, f2, f;
    tone_t t;
    len = eff_len();
    case (r.cmd)
      CMD_TICK: begin
        if (len == 0 || m_loops == 0) begin
          m_sound = 0; m_freq = 0; m_drive = 0;
        end else begin
          if (m_step >= len) m_step = 0;
          el = r.now - m_start;
          d = m_durs[m_step] < 0 ? 32'(-int'(m_durs[m_step])) : 32'(m_durs[m_step]);
          if (el > d) begin
            if (int'(m_step) + 1 >= len) begin
              if (m_loops > 0) m_loops = m_loops - 1;
              m_step = 0;
            end else begin
              m_step = m_step + 1;
            end
            m_start = r.now;
            el = 0;
          end
          if (m_loops != 0) begin
            if (note_rest(m_notes[m_step])) begin
              m_sound = 0; m_freq = 0;
            end else begin
              f1 = FREQ_TABLE[m_notes[m_step][6:0]];
              f = f1;
              if (m_durs[m_step] < 0) begin
                d = 32'(-int'(m_durs[m_step]));
                if (!note_rest(m_notes[(int'(m_step) + 1) % len])) begin
                  e = el > d ? d : el;
                  f2 = FREQ_TABLE[m_notes[(int'(m_step) + 1) % len][6:0]];
                  f = (f1 * (d - e) + f2 * e) / d;
                end
              end
              m_sound = 1; m_freq = 13'(f);
            end
          end
        end
      end
      CMD_LOAD: begin
        m_notes[r.idx] = r.note; m_durs[r.idx] = r.dur;
      end
      CMD_PLAY: begin
        m_step = 0; m_start = r.now; m_loops = m_loop_cfg; m_drive = 1;
      end
      default: m_loops = 0;
    endcase
    t.sound = m_sound; t.freq = m_freq; t.drive = m_drive; t.step = m_step;
    t.playing = (m_loops != 0) && (eff_len() > 0);
    return t;
  endfunction

  always @(posedge clk) begin
    tone_t got, want;
    cycles <= cycles + 1;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_sound_on, out_frequency_hz, out_drive_enable, out_step_index, out_playing};
      results_seen <= results_seen + 1;
      if (expected_tones.size() == 0) begin
        $display("%0t unexpected result actual=%p", $realtime, got);
        errors <= errors + 1;
      end else begin
        want = expected_tones.pop_front();
        if (got !== want) begin
          $display("%0t mismatch expected=%p actual=%p", $realtime, want, got);
          errors <= errors + 1;
        end
      end
    end
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        out_wait = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 16));
      end else if (out_valid && out_wait > 0) begin
        out_wait = out_wait - 1;
      end
      out_stall <= (out_wait != 0);
    end
    if (cycles > 3000000) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  task automatic write_reg(logic idx, logic [8:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SEQ_LENGTH) m_len = val[6:0];
    else m_loop_cfg = val;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_tones.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic send(row_t r);
    tone_t t;
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 16));
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1; in_command <= r.cmd; in_now_ms <= r.now;
    in_entry_index <= r.idx; in_entry_note <= r.note; in_entry_duration <= r.dur;
    t = predict_tone(r);
    if (r.has_exp && t !== r.exp_tone) begin
      $display("%0t table row expected=%p predicted=%p", $realtime, r.exp_tone, t);
      errors++;
    end
    expected_tones.push_back(t);
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic row_t mk(logic [1:0] c, logic [31:0] n, logic [5:0] i,
                              logic signed [7:0] no, logic signed [15:0] du);
    row_t r;
    r.cmd = c; r.now = n; r.idx = i; r.note = no; r.dur = du; r.has_exp = 0;
    r.exp_tone = '0;
    return r;
  endfunction

  function automatic row_t mk_exp(row_t r, tone_t t);
    r.has_exp = 1; r.exp_tone = t;
    return r;
  endfunction

  task automatic tick_for(int span);
    clock_ms += $urandom_range(0, span);
    send(mk(CMD_TICK, clock_ms, 0, 0, 0));
  endtask

  row_t directed [$];

  initial begin
    m_len = 0; m_loop_cfg = 1; m_step = 0; m_start = 0; m_loops = 0;
    m_freq = 0; m_sound = 0; m_drive = 0;
    foreach (m_notes[k]) begin m_notes[k] = 0; m_durs[k] = 0; end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed.push_back(mk_exp(mk(CMD_TICK, 0, 0, 0, 0), '0));
    directed.push_back(mk(CMD_LOAD, 0, 0, 0, 16'sd2));
    directed.push_back(mk(CMD_LOAD, 0, 1, 8'sd83, -16'sd4));
    directed.push_back(mk(CMD_LOAD, 0, 2, 8'sd33, -16'sd10));
    directed.push_back(mk(CMD_LOAD, 0, 3, -8'sd128, 16'sd32767));
    directed.push_back(mk(CMD_LOAD, 0, 4, 8'sd127, -16'sd32768));
    directed.push_back(mk(CMD_LOAD, 0, 63, 8'sd48, 16'sd0));
    foreach (directed[k]) send(directed[k]);
    directed.delete();
    wait_drained();
    write_reg(CFG_SEQ_LENGTH, 9'd3);
    write_reg(CFG_LOOP_COUNT, 9'd1);
    directed.push_back(mk_exp(mk(CMD_PLAY, 32'hFFFF_FFFE, 0, 0, 0),
                              '{1'b0, 13'd0, 1'b1, 6'd0, 1'b1}));
    directed.push_back(mk_exp(mk(CMD_TICK, 32'hFFFF_FFFF, 0, 0, 0),
                              '{1'b1, 13'd65, 1'b1, 6'd0, 1'b1}));
    directed.push_back(mk(CMD_TICK, 32'd1, 0, 0, 0));
    directed.push_back(mk(CMD_TICK, 32'd3, 0, 0, 0));
    directed.push_back(mk(CMD_TICK, 32'd6, 0, 0, 0));
    directed.push_back(mk(CMD_TICK, 32'd12, 0, 0, 0));
    directed.push_back(mk(CMD_TICK, 32'd20, 0, 0, 0));
    directed.push_back(mk(CMD_TICK, 32'd40, 0, 0, 0));
    directed.push_back(mk(CMD_TICK, 32'd41, 0, 0, 0));
    directed.push_back(mk(CMD_STOP, 0, 0, 0, 0));
    directed.push_back(mk(CMD_TICK, 32'd50, 0, 0, 0));
    foreach (directed[k]) send(directed[k]);
    wait_drained();
    write_reg(CFG_SEQ_LENGTH, 9'd64);
    write_reg(CFG_LOOP_COUNT, 9'h1FF);

    for (int k = 0; k < 64; k++)
      send(mk(CMD_LOAD, 0, 6'(k), 8'($urandom_range(0, 99)),
              16'($urandom_range(0, 1) ? -int'($urandom_range(0, 30))
                                       : int'($urandom_range(0, 30)))));
    for (int b = 0; b < 16; b++) begin
      wait_drained();
      case (b % 4)
        0: write_reg(CFG_SEQ_LENGTH, 9'($urandom_range(1, 8)));
        1: write_reg(CFG_SEQ_LENGTH, 9'($urandom_range(65, 127)));
        2: write_reg(CFG_SEQ_LENGTH, 9'd0);
        default: write_reg(CFG_SEQ_LENGTH, 9'($urandom_range(1, 64)));
      endcase
      write_reg(CFG_LOOP_COUNT, b % 3 == 0 ? 9'h1FF : 9'($urandom_range(0, 3)));
      if (b == 8) write_reg(CFG_LOOP_COUNT, 9'd255);
      clock_ms = $urandom;
      send(mk(CMD_PLAY, clock_ms, 0, 0, 0));
      for (int k = 0; k < 30; k++) begin
        case ($urandom_range(0, 19))
          0: send(mk(CMD_STOP, $urandom, 6'($urandom), 8'($urandom), 16'($urandom)));
          1: send(mk(CMD_LOAD, 0, 6'($urandom), 8'($urandom),
                     16'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 40))));
          2: send(mk(CMD_PLAY, clock_ms, 0, 0, 0));
          3: tick_for(40000);
          default: tick_for(40);
        endcase
      end
      if (b == 5) begin
        wait_drained();
        write_reg(CFG_SEQ_LENGTH, 9'd2);
        tick_for(5);
      end
    end
    wait_drained();
    $display("testbench: %0d results checked across looping, glide, rest and length changes",
             results_seen);
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* sim.f */
sv/mgs_pkg.sv
sv/mgs_ram.sv
sv/mgs_ctrl.sv
sv/mgs_datapath.sv
sv/melody_glide_sequencer.sv
sv/mgs_checker.sv
test/testbench.sv
